// ===== rtl/core/sdtw_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtw_pkg
// Shared types and constants for the subsequence DTW matcher.
// ----------------------------------------------------------------------------
package sdtw_pkg;

  localparam int QUERY_MAX_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF  = 20;
  localparam int COST_BITS_DEF   = 32;

  localparam int QIDX_BITS = 6;
  localparam int QLEN_BITS = 7;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_SERIES = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/sdtw_cell.sv =====
// ----------------------------------------------------------------------------
// sdtw_cell
// One query row of the DTW column: holds a query sample, the row cost and
// the start index, and hands the wavefront to the next row each cycle.
// ----------------------------------------------------------------------------
module sdtw_cell import sdtw_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          active,
  input  logic                          q_wr,
  input  logic signed [SAMPLE_BITS-1:0] q_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          tin_valid,
  input  logic [COST_BITS-1:0]          up_cost_in,
  input  logic [INDEX_BITS-1:0]         up_start_in,
  input  logic [COST_BITS-1:0]          diag_cost_in,
  input  logic [INDEX_BITS-1:0]         diag_start_in,
  output logic                          tout_valid,
  output logic [COST_BITS-1:0]          up_cost_out,
  output logic [INDEX_BITS-1:0]         up_start_out,
  output logic [COST_BITS-1:0]          diag_cost_out,
  output logic [INDEX_BITS-1:0]         diag_start_out
);

  localparam int WW = ((SAMPLE_BITS > COST_BITS) ? SAMPLE_BITS : COST_BITS) + 1;
  localparam logic [COST_BITS-1:0] INF = '1;

  logic signed [SAMPLE_BITS-1:0] q_r;
  logic [COST_BITS-1:0]          cost_r;
  logic [INDEX_BITS-1:0]         start_r;
  logic                          tok_r;
  logic [COST_BITS-1:0]          up_cost_r;
  logic [INDEX_BITS-1:0]         up_start_r;
  logic [COST_BITS-1:0]          diag_cost_r;
  logic [INDEX_BITS-1:0]         diag_start_r;

  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [WW-1:0]                 mag_w;
  logic [WW-1:0]                 inf_w;
  logic [COST_BITS-1:0]          cell_cost;
  logic [COST_BITS-1:0]          pick_cost;
  logic [INDEX_BITS-1:0]         pick_start;
  logic [COST_BITS:0]            sum;
  logic [COST_BITS-1:0]          cost_nxt;
  logic [INDEX_BITS-1:0]         start_nxt;

  always_comb begin
    diff  = {q_r[SAMPLE_BITS-1], q_r} - {sample[SAMPLE_BITS-1], sample};
    mag   = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
    mag_w = WW'(mag);
    inf_w = WW'(INF);
    cell_cost = (mag_w >= inf_w) ? INF : mag_w[COST_BITS-1:0];

    if (diag_cost_in <= up_cost_in && diag_cost_in <= cost_r) begin
      pick_cost  = diag_cost_in;
      pick_start = diag_start_in;
    end else if (up_cost_in < cost_r) begin
      pick_cost  = up_cost_in;
      pick_start = up_start_in;
    end else begin
      pick_cost  = cost_r;
      pick_start = start_r;
    end

    sum = {1'b0, cell_cost} + {1'b0, pick_cost};
    if (cell_cost == INF || pick_cost == INF || sum >= {1'b0, INF}) begin
      cost_nxt = INF;
    end else begin
      cost_nxt = sum[COST_BITS-1:0];
    end
    start_nxt = pick_start;
  end

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cost_r  <= INF;
      start_r <= '0;
    end else if (tin_valid && active) begin
      cost_r  <= cost_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tin_valid;
    end
  end

  // register the wavefront for the next row; rows beyond the query length pass it through
  always_ff @(posedge clk) begin
    if (tin_valid) begin
      up_cost_r    <= active ? cost_nxt : up_cost_in;
      up_start_r   <= active ? start_nxt : up_start_in;
      diag_cost_r  <= cost_r;
      diag_start_r <= start_r;
    end
  end

  assign tout_valid     = tok_r;
  assign up_cost_out    = up_cost_r;
  assign up_start_out   = up_start_r;
  assign diag_cost_out  = diag_cost_r;
  assign diag_start_out = diag_start_r;

endmodule

// ===== rtl/core/subsequence_dtw_matcher_core.sv =====
// Series beat: in_tready drops while the wavefront walks the full cell chain
//   (one row per cycle) and, after tlast, until the result is loaded.
// Query load beat: one per cycle, in_tready stays high.
// Result: out_tvalid rises after the last series beat has walked the chain.
// Reset (synchronous, rst_n low): column and best cost to infinity, best
//   indices and position to zero, query length to one; query kept as is.
// ----------------------------------------------------------------------------
// subsequence_dtw_matcher_core
// Subsequence DTW matcher: a chain of query-row cells updates one DTW column
// per series sample and tracks the best bottom-row cost.
// ----------------------------------------------------------------------------
module subsequence_dtw_matcher_core import sdtw_pkg::*; #(
  parameter int QUERY_MAX   = QUERY_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF,
  localparam int IN_W  = ((QIDX_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((COST_BITS + 2 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [QLEN_BITS-1:0] cfg_data,    // query_length
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,    // query_index, sample
  input  logic                 in_tuser,    // op
  input  logic                 in_tlast,    // last
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata    // distance, start_index, end_index
);

  localparam int LEN_W = $clog2(QUERY_MAX + 1);
  localparam logic [COST_BITS-1:0] INF = '1;

  state_t state_r, state_nxt;

  logic                          in_beat;
  logic                          series_beat;
  logic                          query_beat;
  logic [QIDX_BITS-1:0]          in_qidx;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  logic [LEN_W-1:0]              len_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;
  logic                          tok0_r;
  logic [INDEX_BITS-1:0]         pos_r;
  logic [COST_BITS-1:0]          best_cost_r;
  logic [INDEX_BITS-1:0]         best_start_r;
  logic [INDEX_BITS-1:0]         best_end_r;
  logic                          out_valid_r;
  logic [COST_BITS-1:0]          out_dist_r;
  logic [INDEX_BITS-1:0]         out_start_r;
  logic [INDEX_BITS-1:0]         out_end_r;

  logic                          tail_done;
  logic                          load_out;
  logic                          clear_series;

  logic [QUERY_MAX:0]            tok_v;
  logic [COST_BITS-1:0]          up_cost   [QUERY_MAX+1];
  logic [INDEX_BITS-1:0]         up_start  [QUERY_MAX+1];
  logic [COST_BITS-1:0]          diag_cost [QUERY_MAX+1];
  logic [INDEX_BITS-1:0]         diag_start[QUERY_MAX+1];
  logic [QUERY_MAX-1:0]          cell_act;
  logic [QUERY_MAX-1:0]          cell_wr;

  assign in_qidx     = in_tdata[QIDX_BITS-1:0];
  assign in_sample   = in_tdata[QIDX_BITS +: SAMPLE_BITS];
  assign in_beat     = in_tvalid && in_tready;
  assign series_beat = in_beat && (in_tuser == OP_SERIES);
  assign query_beat  = in_beat && (in_tuser == OP_QUERY);
  assign tail_done   = tok_v[QUERY_MAX];
  assign cfg_ready   = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    load_out     = 1'b0;
    clear_series = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == OP_SERIES) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tail_done) begin
          state_nxt = last_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          load_out     = 1'b1;
          clear_series = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        len_r <= LEN_W'(1);
      end else if (32'(cfg_data) > QUERY_MAX) begin
        len_r <= LEN_W'(QUERY_MAX);
      end else begin
        len_r <= LEN_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (series_beat) begin
      sample_r <= in_sample;
      last_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= 1'b0;
    end else begin
      tok0_r <= series_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_series) begin
      pos_r        <= '0;
      best_cost_r  <= INF;
      best_start_r <= '0;
      best_end_r   <= '0;
    end else if (state_r == ST_RUN && tail_done) begin
      pos_r <= pos_r + INDEX_BITS'(1);
      if (up_cost[QUERY_MAX] < best_cost_r) begin
        best_cost_r  <= up_cost[QUERY_MAX];
        best_start_r <= up_start[QUERY_MAX];
        best_end_r   <= pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dist_r  <= best_cost_r;
      out_start_r <= best_start_r;
      out_end_r   <= best_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_end_r, out_start_r, out_dist_r});

  // row zero of the matrix counts as zero and starts at the current position
  assign tok_v[0]      = tok0_r;
  assign up_cost[0]    = '0;
  assign up_start[0]   = pos_r;
  assign diag_cost[0]  = '0;
  assign diag_start[0] = pos_r;

  for (genvar i = 0; i < QUERY_MAX; i++) begin : g_cell
    assign cell_act[i] = (32'(len_r) > i);
    assign cell_wr[i]  = query_beat && (32'(in_qidx) == i);

    sdtw_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX_BITS  (INDEX_BITS),
      .COST_BITS   (COST_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .clear          (clear_series),
      .active         (cell_act[i]),
      .q_wr           (cell_wr[i]),
      .q_data         (in_sample),
      .sample         (sample_r),
      .tin_valid      (tok_v[i]),
      .up_cost_in     (up_cost[i]),
      .up_start_in    (up_start[i]),
      .diag_cost_in   (diag_cost[i]),
      .diag_start_in  (diag_start[i]),
      .tout_valid     (tok_v[i+1]),
      .up_cost_out    (up_cost[i+1]),
      .up_start_out   (up_start[i+1]),
      .diag_cost_out  (diag_cost[i+1]),
      .diag_start_out (diag_start[i+1])
    );
  end

endmodule

// ===== rtl/core/sdtw_checker.sv =====
// ----------------------------------------------------------------------------
// sdtw_checker
// Port-level checks for the subsequence DTW matcher, bound to the matcher core.
// ----------------------------------------------------------------------------
module sdtw_checker import sdtw_pkg::*; #(
  parameter int QUERY_MAX   = QUERY_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF,
  localparam int OUT_W = ((COST_BITS + 2 * INDEX_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam logic [COST_BITS-1:0] INF = '1;

  logic [COST_BITS-1:0] res_dist;
  logic                 no_match;

  assign res_dist = out_tdata[COST_BITS-1:0];
  assign no_match = out_tvalid && (res_dist == INF);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_series_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_SERIES) |=> !in_tready)
    else $error("series beat did not occupy the cell chain");

  a_query_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> in_tready)
    else $error("query load stalled the input");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a finished series");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    no_match |-> out_tdata[COST_BITS +: 2 * INDEX_BITS] == '0)
    else $error("infinite distance with nonzero indices");

endmodule

bind subsequence_dtw_matcher_core sdtw_checker #(
  .QUERY_MAX   (QUERY_MAX),
  .SAMPLE_BITS (SAMPLE_BITS),
  .INDEX_BITS  (INDEX_BITS),
  .COST_BITS   (COST_BITS)
) u_sdtw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
